/* sv/rtch_pkg.sv */
package rtch_pkg;

	// coordinate and internal widths
	localparam int COORD_W = 32;
	localparam int IDX_W = 16;
	localparam int EDGE_W = 34;
	localparam int WIDE_W = 68;
	localparam int ACC_W = 104;
	localparam int DIG_W = 16;
	localparam int NDIG = 5;
	localparam int EXT_W = DIG_W * NDIG;
	localparam int PP_W = EDGE_W + DIG_W + 1;
	localparam int NSTEP = 24;
	localparam int DIV_W = 133;
	localparam int Q_W = 31;
	localparam int UV_W = 17;
	localparam int MAX_TRIANGLES = 65536;
	localparam int QDEPTH = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} reg_idx_t;

	// narrow multiplier operands
	typedef enum logic [3:0] {
		B_DIR_X = 4'd0, B_DIR_Y = 4'd1, B_DIR_Z = 4'd2,
		B_E1_X  = 4'd3, B_E1_Y  = 4'd4, B_E1_Z  = 4'd5,
		B_E2_X  = 4'd6, B_E2_Y  = 4'd7, B_E2_Z  = 4'd8,
		B_S_X   = 4'd9, B_S_Y   = 4'd10, B_S_Z  = 4'd11
	} b_src_t;

	// wide multiplier operands
	typedef enum logic [3:0] {
		A_E1_X = 4'd0, A_E1_Y = 4'd1, A_E1_Z = 4'd2,
		A_E2_X = 4'd3, A_E2_Y = 4'd4, A_E2_Z = 4'd5,
		A_H_X  = 4'd6, A_H_Y  = 4'd7, A_H_Z  = 4'd8,
		A_Q_X  = 4'd9, A_Q_Y  = 4'd10, A_Q_Z = 4'd11
	} a_src_t;

	// accumulator destinations
	typedef enum logic [3:0] {
		D_NONE = 4'd0,
		D_H_X  = 4'd1, D_H_Y = 4'd2, D_H_Z = 4'd3,
		D_Q_X  = 4'd4, D_Q_Y = 4'd5, D_Q_Z = 4'd6,
		D_DET  = 4'd7, D_UN  = 4'd8, D_VN  = 4'd9, D_TN = 4'd10
	} dst_t;

	typedef struct packed {
		a_src_t a_sel;
		b_src_t b_sel;
		logic   neg;
		logic   first;
		logic   last;
		dst_t   dst;
	} step_t;

	// one triangle after the front end
	typedef struct packed {
		logic              first;
		logic              idx_ok;
		logic [IDX_W-1:0]  idx;
		edge_t [2:0]       e1;
		edge_t [2:0]       e2;
		edge_t [2:0]       s;
	} tri_item_t;

	function automatic step_t mk(input a_src_t a, input b_src_t b, input logic n,
			input logic f, input logic l, input dst_t d);
		step_t r;
		r.a_sel = a;
		r.b_sel = b;
		r.neg = n;
		r.first = f;
		r.last = l;
		r.dst = d;
		return r;
	endfunction

	// product sequence: h = dir x e2, q = s x e1, then the four dot products
	function automatic step_t step_info(input logic [4:0] n);
		step_t r;
		unique case (n)
			5'd0:  r = mk(A_E2_Z, B_DIR_Y, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd1:  r = mk(A_E2_Y, B_DIR_Z, 1'b1, 1'b0, 1'b1, D_H_X);
			5'd2:  r = mk(A_E2_X, B_DIR_Z, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd3:  r = mk(A_E2_Z, B_DIR_X, 1'b1, 1'b0, 1'b1, D_H_Y);
			5'd4:  r = mk(A_E2_Y, B_DIR_X, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd5:  r = mk(A_E2_X, B_DIR_Y, 1'b1, 1'b0, 1'b1, D_H_Z);
			5'd6:  r = mk(A_E1_Z, B_S_Y, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd7:  r = mk(A_E1_Y, B_S_Z, 1'b1, 1'b0, 1'b1, D_Q_X);
			5'd8:  r = mk(A_E1_X, B_S_Z, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd9:  r = mk(A_E1_Z, B_S_X, 1'b1, 1'b0, 1'b1, D_Q_Y);
			5'd10: r = mk(A_E1_Y, B_S_X, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd11: r = mk(A_E1_X, B_S_Y, 1'b1, 1'b0, 1'b1, D_Q_Z);
			5'd12: r = mk(A_H_X, B_E1_X, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd13: r = mk(A_H_Y, B_E1_Y, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd14: r = mk(A_H_Z, B_E1_Z, 1'b0, 1'b0, 1'b1, D_DET);
			5'd15: r = mk(A_H_X, B_S_X, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd16: r = mk(A_H_Y, B_S_Y, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd17: r = mk(A_H_Z, B_S_Z, 1'b0, 1'b0, 1'b1, D_UN);
			5'd18: r = mk(A_Q_X, B_DIR_X, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd19: r = mk(A_Q_Y, B_DIR_Y, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd20: r = mk(A_Q_Z, B_DIR_Z, 1'b0, 1'b0, 1'b1, D_VN);
			5'd21: r = mk(A_Q_X, B_E2_X, 1'b0, 1'b1, 1'b0, D_NONE);
			5'd22: r = mk(A_Q_Y, B_E2_Y, 1'b0, 1'b0, 1'b0, D_NONE);
			5'd23: r = mk(A_Q_Z, B_E2_Z, 1'b0, 1'b0, 1'b1, D_TN);
			default: r = mk(A_E1_X, B_DIR_X, 1'b0, 1'b0, 1'b0, D_NONE);
		endcase
		return r;
	endfunction

endpackage

/* sv/rtch_front.sv */
module rtch_front (
	input  logic [303:0]              s_tdata,
	input  logic [0:0]                s_tuser,
	input  rtch_pkg::coord_t [2:0]    origin,
	output rtch_pkg::tri_item_t       item
);

	rtch_pkg::coord_t [2:0] p0, p1, p2;
	logic [rtch_pkg::IDX_W-1:0] idx;

	// field unpacking
	always_comb begin
		idx = s_tdata[15:0];
		for (int k = 0; k < 3; k++) begin
			p0[k] = s_tdata[16 + 32*k +: 32];
			p1[k] = s_tdata[112 + 32*k +: 32];
			p2[k] = s_tdata[208 + 32*k +: 32];
		end
	end

	// edges, origin offset and index range check
	always_comb begin
		item.first = s_tuser[0];
		item.idx = idx;
		item.idx_ok = (32'(idx) < rtch_pkg::MAX_TRIANGLES);
		for (int k = 0; k < 3; k++) begin
			item.e1[k] = rtch_pkg::EDGE_W'($signed(p1[k])) -
				rtch_pkg::EDGE_W'($signed(p0[k]));
			item.e2[k] = rtch_pkg::EDGE_W'($signed(p2[k])) -
				rtch_pkg::EDGE_W'($signed(p0[k]));
			item.s[k] = rtch_pkg::EDGE_W'($signed(origin[k])) -
				rtch_pkg::EDGE_W'($signed(p0[k]));
		end
	end

endmodule

/* sv/rtch_queue.sv */
module rtch_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rtch_pkg::tri_item_t  push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 avail,
	output rtch_pkg::tri_item_t  pop_item
);

	rtch_pkg::tri_item_t mem_q [rtch_pkg::QDEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'(rtch_pkg::QDEPTH));
	assign avail = (cnt_q != 2'd0);
	assign pop_item = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= push_item;
	end

endmodule

/* sv/rtch_back.sv */
module rtch_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         avail,
	input  rtch_pkg::tri_item_t          item,
	output logic                         pop,
	input  rtch_pkg::coord_t [2:0]       dir,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic                         hit_now,
	output logic                         any_hit,
	output logic [rtch_pkg::Q_W-1:0]     closest_t,
	output logic [rtch_pkg::UV_W-1:0]    closest_u,
	output logic [rtch_pkg::UV_W-1:0]    closest_v,
	output logic [rtch_pkg::IDX_W-1:0]   closest_index
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_DRAIN, ST_SIGN, ST_TEST,
		ST_DINIT, ST_DRUN, ST_DFIN, ST_RES
	} state_t;

	typedef enum logic [1:0] {SEL_T, SEL_U, SEL_V} qsel_t;

	state_t state_q;
	qsel_t sel_q;

	rtch_pkg::edge_t src_q [12];
	rtch_pkg::wide_t hq_q [6];
	rtch_pkg::acc_t acc_q, det_q, un_q, vn_q, tn_q;
	logic [rtch_pkg::IDX_W-1:0] idx_q;
	logic [4:0] step_q;
	logic [2:0] dig_q;

	logic [rtch_pkg::DIV_W-1:0] rem_q, dk_q;
	logic [rtch_pkg::Q_W-1:0] q_q, tq_q, uq_q;
	logic [4:0] cnt_q;

	logic [rtch_pkg::Q_W-1:0] best_t_q;
	logic [rtch_pkg::UV_W-1:0] best_u_q, best_v_q;
	logic [rtch_pkg::IDX_W-1:0] best_tri_q;
	logic hit_seen_q, hit_now_q;

	// multiplier pipeline
	logic signed [rtch_pkg::PP_W-1:0] pp_s1;
	logic [2:0] dig_s1;
	logic neg_s1, clr_s1, v_s1;
	rtch_pkg::dst_t dst_s1;

	rtch_pkg::step_t st;
	rtch_pkg::wide_t a_val;
	logic signed [rtch_pkg::EXT_W-1:0] a_ext;
	logic [rtch_pkg::DIG_W-1:0] dig_raw;
	logic signed [rtch_pkg::DIG_W:0] dig_val;
	logic signed [rtch_pkg::PP_W-1:0] pp;
	rtch_pkg::acc_t term, shifted, sum;

	rtch_pkg::acc_t num_sel, uv_sum;
	logic [rtch_pkg::DIV_W-1:0] num_w, det_w, rem_sub;
	logic div_ge, pass;

	function automatic rtch_pkg::wide_t ext_a(input rtch_pkg::edge_t x);
		return rtch_pkg::WIDE_W'(x);
	endfunction

	assign pop = (state_q == ST_IDLE) && avail;

	// operand selection and one digit product
	always_comb begin
		st = rtch_pkg::step_info(step_q);
		unique case (st.a_sel)
			rtch_pkg::A_E1_X: a_val = ext_a(src_q[rtch_pkg::B_E1_X]);
			rtch_pkg::A_E1_Y: a_val = ext_a(src_q[rtch_pkg::B_E1_Y]);
			rtch_pkg::A_E1_Z: a_val = ext_a(src_q[rtch_pkg::B_E1_Z]);
			rtch_pkg::A_E2_X: a_val = ext_a(src_q[rtch_pkg::B_E2_X]);
			rtch_pkg::A_E2_Y: a_val = ext_a(src_q[rtch_pkg::B_E2_Y]);
			rtch_pkg::A_E2_Z: a_val = ext_a(src_q[rtch_pkg::B_E2_Z]);
			rtch_pkg::A_H_X:  a_val = hq_q[0];
			rtch_pkg::A_H_Y:  a_val = hq_q[1];
			rtch_pkg::A_H_Z:  a_val = hq_q[2];
			rtch_pkg::A_Q_X:  a_val = hq_q[3];
			rtch_pkg::A_Q_Y:  a_val = hq_q[4];
			rtch_pkg::A_Q_Z:  a_val = hq_q[5];
			default:          a_val = '0;
		endcase
		a_ext = rtch_pkg::EXT_W'(a_val);
		dig_raw = a_ext[{dig_q, 4'b0000} +: rtch_pkg::DIG_W];
		if (dig_q == 3'(rtch_pkg::NDIG - 1))
			dig_val = {dig_raw[rtch_pkg::DIG_W-1], dig_raw};
		else
			dig_val = {1'b0, dig_raw};
		pp = rtch_pkg::PP_W'(src_q[st.b_sel]) * rtch_pkg::PP_W'(dig_val);
	end

	// accumulate the registered digit product
	always_comb begin
		shifted = rtch_pkg::ACC_W'(pp_s1) <<< {dig_s1, 4'b0000};
		term = neg_s1 ? -shifted : shifted;
		sum = (clr_s1 ? '0 : acc_q) + term;
	end

	// divider step and hit test
	always_comb begin
		unique case (sel_q)
			SEL_T:   num_sel = tn_q;
			SEL_U:   num_sel = un_q;
			SEL_V:   num_sel = vn_q;
			default: num_sel = tn_q;
		endcase
		num_w = rtch_pkg::DIV_W'($unsigned(num_sel));
		det_w = rtch_pkg::DIV_W'($unsigned(det_q));
		div_ge = (rem_q >= dk_q);
		rem_sub = rem_q - dk_q;
		uv_sum = un_q + vn_q;
		pass = !un_q[rtch_pkg::ACC_W-1] && (un_q <= det_q) &&
			!vn_q[rtch_pkg::ACC_W-1] && (uv_sum <= det_q) &&
			!tn_q[rtch_pkg::ACC_W-1] && (tn_q != '0);
	end

	// multiplier issue stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			pp_s1 <= '0;
			dig_s1 <= '0;
			neg_s1 <= 1'b0;
			clr_s1 <= 1'b0;
			dst_s1 <= rtch_pkg::D_NONE;
		end else begin
			v_s1 <= (state_q == ST_MUL);
			pp_s1 <= pp;
			dig_s1 <= dig_q;
			neg_s1 <= st.neg;
			clr_s1 <= st.first && (dig_q == 3'd0);
			dst_s1 <= (st.last && dig_q == 3'(rtch_pkg::NDIG - 1)) ? st.dst : rtch_pkg::D_NONE;
		end
	end

	// sequencer, accumulator, divider and closest-hit record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= SEL_T;
			for (int k = 0; k < 12; k++)
				src_q[k] <= '0;
			for (int k = 0; k < 6; k++)
				hq_q[k] <= '0;
			acc_q <= '0;
			det_q <= '0;
			un_q <= '0;
			vn_q <= '0;
			tn_q <= '0;
			idx_q <= '0;
			step_q <= '0;
			dig_q <= '0;
			rem_q <= '0;
			dk_q <= '0;
			q_q <= '0;
			tq_q <= '0;
			uq_q <= '0;
			cnt_q <= '0;
			best_t_q <= '1;
			best_u_q <= '0;
			best_v_q <= '0;
			best_tri_q <= '0;
			hit_seen_q <= 1'b0;
			hit_now_q <= 1'b0;
			m_tvalid <= 1'b0;
			hit_now <= 1'b0;
			any_hit <= 1'b0;
			closest_t <= '0;
			closest_u <= '0;
			closest_v <= '0;
			closest_index <= '0;
		end else begin
			// result taken and no new one issued this cycle
			if (m_tvalid && m_tready && state_q != ST_RES)
				m_tvalid <= 1'b0;

			// accumulator write-back
			if (v_s1) begin
				acc_q <= sum;
				unique case (dst_s1)
					rtch_pkg::D_H_X: hq_q[0] <= rtch_pkg::WIDE_W'(sum);
					rtch_pkg::D_H_Y: hq_q[1] <= rtch_pkg::WIDE_W'(sum);
					rtch_pkg::D_H_Z: hq_q[2] <= rtch_pkg::WIDE_W'(sum);
					rtch_pkg::D_Q_X: hq_q[3] <= rtch_pkg::WIDE_W'(sum);
					rtch_pkg::D_Q_Y: hq_q[4] <= rtch_pkg::WIDE_W'(sum);
					rtch_pkg::D_Q_Z: hq_q[5] <= rtch_pkg::WIDE_W'(sum);
					rtch_pkg::D_DET: det_q <= sum;
					rtch_pkg::D_UN:  un_q <= sum;
					rtch_pkg::D_VN:  vn_q <= sum;
					rtch_pkg::D_TN:  tn_q <= sum;
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (avail) begin
						for (int k = 0; k < 3; k++) begin
							src_q[k] <= rtch_pkg::EDGE_W'($signed(dir[k]));
							src_q[3 + k] <= item.e1[k];
							src_q[6 + k] <= item.e2[k];
							src_q[9 + k] <= item.s[k];
						end
						idx_q <= item.idx;
						hit_now_q <= 1'b0;
						step_q <= '0;
						dig_q <= '0;
						if (item.first) begin
							best_t_q <= '1;
							best_u_q <= '0;
							best_v_q <= '0;
							best_tri_q <= '0;
							hit_seen_q <= 1'b0;
						end
						state_q <= item.idx_ok ? ST_MUL : ST_RES;
					end
				end
				ST_MUL: begin
					if (dig_q == 3'(rtch_pkg::NDIG - 1)) begin
						dig_q <= '0;
						step_q <= step_q + 5'd1;
						if (step_q == 5'(rtch_pkg::NSTEP - 1))
							state_q <= ST_DRAIN;
					end else begin
						dig_q <= dig_q + 3'd1;
					end
				end
				ST_DRAIN: state_q <= ST_SIGN;
				ST_SIGN: begin
					if (det_q == '0) begin
						state_q <= ST_RES;
					end else begin
						if (det_q[rtch_pkg::ACC_W-1]) begin
							det_q <= -det_q;
							un_q <= -un_q;
							vn_q <= -vn_q;
							tn_q <= -tn_q;
						end
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					sel_q <= SEL_T;
					state_q <= pass ? ST_DINIT : ST_RES;
				end
				ST_DINIT: begin
					// saturate when the quotient would not fit
					if (num_w >= (det_w << 15)) begin
						q_q <= '1;
						state_q <= ST_DFIN;
					end else begin
						q_q <= '0;
						rem_q <= num_w << 16;
						dk_q <= det_w << 30;
						cnt_q <= 5'(rtch_pkg::Q_W - 1);
						state_q <= ST_DRUN;
					end
				end
				ST_DRUN: begin
					if (div_ge)
						rem_q <= rem_sub;
					dk_q <= dk_q >> 1;
					q_q <= {q_q[rtch_pkg::Q_W-2:0], div_ge};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0)
						state_q <= ST_DFIN;
				end
				ST_DFIN: begin
					unique case (sel_q)
						SEL_T: begin
							if (q_q != '0 && q_q < best_t_q) begin
								tq_q <= q_q;
								sel_q <= SEL_U;
								state_q <= ST_DINIT;
							end else begin
								state_q <= ST_RES;
							end
						end
						SEL_U: begin
							uq_q <= q_q;
							sel_q <= SEL_V;
							state_q <= ST_DINIT;
						end
						default: begin
							best_t_q <= tq_q;
							best_u_q <= uq_q[rtch_pkg::UV_W-1:0];
							best_v_q <= q_q[rtch_pkg::UV_W-1:0];
							best_tri_q <= idx_q;
							hit_seen_q <= 1'b1;
							hit_now_q <= 1'b1;
							state_q <= ST_RES;
						end
					endcase
				end
				ST_RES: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						hit_now <= hit_now_q;
						any_hit <= hit_seen_q;
						closest_t <= best_t_q;
						closest_u <= best_u_q;
						closest_v <= best_v_q;
						closest_index <= best_tri_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* sv/ray_triangle_closest_hit.sv */
// Closest-hit ray/triangle tester. The ray is written through the cfg port
// (origin x/y/z at indexes 0-2, direction at 3-5, signed Q16.16) by the user,
// who must do so only while the block is idle; the block does not enforce it.
// Each slave item carries one triangle and yields exactly one master item
// with the closest-hit record after that triangle. first_of_ray in s_tuser
// clears the record first. The front end forms the edges and takes items
// into a two-entry queue, so up to two triangles are taken while the back
// end works. The back end does every cross and dot product exactly on one
// shared 34x17 multiplier, 24 products of five digit passes each, then
// divides t, u and v out one quotient bit per cycle (u and v only for a new
// closest hit; an item failing the barycentric test skips the divider).
module ray_triangle_closest_hit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// tri_index, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
	input  logic [303:0] s_tdata,
	// first_of_ray
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// closest_t, closest_u, closest_v, closest_index, zero padding
	output logic [87:0]  m_tdata,
	// hit_now, any_hit
	output logic [1:0]   m_tuser
);

	rtch_pkg::coord_t [2:0] origin_q, dir_q;
	rtch_pkg::tri_item_t front_item, back_item;
	logic q_full, q_avail, q_pop, push;
	logic hit_now, any_hit;
	logic [rtch_pkg::Q_W-1:0] closest_t;
	logic [rtch_pkg::UV_W-1:0] closest_u, closest_v;
	logic [rtch_pkg::IDX_W-1:0] closest_index;

	// ray registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			dir_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtch_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_wdata;
				rtch_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_wdata;
				rtch_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_wdata;
				rtch_pkg::REG_DIR_X:    dir_q[0] <= cfg_wdata;
				rtch_pkg::REG_DIR_Y:    dir_q[1] <= cfg_wdata;
				rtch_pkg::REG_DIR_Z:    dir_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign push = s_tvalid && !q_full;

	rtch_front u_front (
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.origin  (origin_q),
		.item    (front_item)
	);

	rtch_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.pop_item  (back_item)
	);

	rtch_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.avail         (q_avail),
		.item          (back_item),
		.pop           (q_pop),
		.dir           (dir_q),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.hit_now       (hit_now),
		.any_hit       (any_hit),
		.closest_t     (closest_t),
		.closest_u     (closest_u),
		.closest_v     (closest_v),
		.closest_index (closest_index)
	);

	assign m_tdata = {7'b0, closest_index, closest_v, closest_u, closest_t};
	assign m_tuser = {any_hit, hit_now};

	// a new closest hit always leaves a hit in the record
	a_hit_seen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hit_now |-> any_hit)
		else $error("hit_now without any_hit");

	// an empty record reads as the cleared values
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !any_hit |-> (closest_t == '1) && (closest_index == '0) &&
			(closest_u == '0) && (closest_v == '0))
		else $error("empty record not cleared");

	// barycentrics of a hit stay within one and its t is nonzero
	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && any_hit |-> (closest_u <= 17'h10000) && (closest_v <= 17'h10000) &&
			(closest_t != '0))
		else $error("closest hit out of range");

endmodule

/* verif/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [255:0] big_t;

	// one closest-hit record as the block reports it
	typedef struct {
		bit          hit_now;
		bit          any_hit;
		logic [30:0] t;
		logic [16:0] u;
		logic [16:0] v;
		logic [15:0] idx;
	} hit_rec_t;

	// closest-hit predictor and the store of records still to arrive
	class hit_scoreboard;
		logic [31:0] ray[6];
		logic [30:0] best_t;
		logic [16:0] best_u, best_v;
		logic [15:0] best_idx;
		bit          hit_seen;
		hit_rec_t    due[$];
		int          errors, results, hits;

		function new();
			foreach (ray[i]) ray[i] = '0;
			clear_record();
		endfunction

		function void clear_record();
			best_t = '1;
			best_u = '0;
			best_v = '0;
			best_idx = '0;
			hit_seen = 0;
		endfunction

		static function big_t ext(logic [31:0] x);
			return big_t'($signed(x));
		endfunction

		static function void cross3(input big_t a[3], input big_t b[3], output big_t r[3]);
			r[0] = a[1] * b[2] - a[2] * b[1];
			r[1] = a[2] * b[0] - a[0] * b[2];
			r[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		static function big_t dot(big_t a[3], big_t b[3]);
			return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
		endfunction

		// floor(n * 2^16 / d), saturated
		static function logic [30:0] quot(big_t n, big_t d);
			big_t q;
			if (n >= (d <<< 15))
				return '1;
			q = (n <<< 16) / d;
			return q[30:0];
		endfunction

		function void note_input(bit first, logic [303:0] d);
			big_t o[3], dir[3], p0[3], p1[3], p2[3], e1[3], e2[3], s[3], h[3], q[3];
			big_t det, un, vn, tn;
			logic [30:0] tq;
			logic [15:0] idx;
			hit_rec_t r;
			idx = d[15:0];
			r.hit_now = 0;
			if (first)
				clear_record();
			for (int i = 0; i < 3; i++) begin
				o[i] = ext(ray[i]);
				dir[i] = ext(ray[3 + i]);
				p0[i] = ext(d[16 + 32 * i +: 32]);
				p1[i] = ext(d[112 + 32 * i +: 32]);
				p2[i] = ext(d[208 + 32 * i +: 32]);
				e1[i] = p1[i] - p0[i];
				e2[i] = p2[i] - p0[i];
				s[i] = o[i] - p0[i];
			end
			cross3(dir, e2, h);
			cross3(s, e1, q);
			det = dot(e1, h);
			un = dot(s, h);
			vn = dot(dir, q);
			tn = dot(e2, q);
			if (int'(idx) < rtch_pkg::MAX_TRIANGLES && det != 0) begin
				if (det < 0) begin
					det = -det;
					un = -un;
					vn = -vn;
					tn = -tn;
				end
				if (un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn > 0) begin
					tq = quot(tn, det);
					if (tq != 0 && tq < best_t) begin
						best_t = tq;
						best_u = quot(un, det);
						best_v = quot(vn, det);
						best_idx = idx;
						hit_seen = 1;
						r.hit_now = 1;
					end
				end
			end
			r.any_hit = hit_seen;
			r.t = best_t;
			r.u = best_u;
			r.v = best_v;
			r.idx = best_idx;
			due.insert(due.size(), r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch at result %0d: %s got %0h expected %0h", results, what, got, want);
			errors++;
		endtask

		task check(logic [87:0] d, logic [1:0] flags);
			hit_rec_t e;
			if (due.size() == 0) begin
				$display("result %0d arrived with nothing expected", results);
				errors++;
			end else begin
				e = due.pop_front();
				if (flags[0] !== e.hit_now) report("hit_now", flags[0], e.hit_now);
				if (flags[1] !== e.any_hit) report("any_hit", flags[1], e.any_hit);
				if (d[30:0] !== e.t) report("closest_t", d[30:0], e.t);
				if (d[47:31] !== e.u) report("closest_u", d[47:31], e.u);
				if (d[64:48] !== e.v) report("closest_v", d[64:48], e.v);
				if (d[80:65] !== e.idx) report("closest_index", d[80:65], e.idx);
				if (d[87:81] !== '0) report("padding", d[87:81], 0);
				hits += e.hit_now;
			end
			results++;
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_we = 0;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [303:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [87:0]  m_tdata;
	logic [1:0]   m_tuser;

	hit_scoreboard sb = new();
	int src_idle, dst_idle, sent;

	ray_triangle_closest_hit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver stalls
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= dst_idle);

	// watch both handshakes
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_input(s_tuser[0], s_tdata);
		if (m_tvalid && m_tready)
			sb.check(m_tdata, m_tuser);
	end

	task wait_idle();
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task write_reg(rtch_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.ray[idx] = val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task set_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
		wait_idle();
		write_reg(rtch_pkg::REG_ORIGIN_X, ox);
		write_reg(rtch_pkg::REG_ORIGIN_Y, oy);
		write_reg(rtch_pkg::REG_ORIGIN_Z, oz);
		write_reg(rtch_pkg::REG_DIR_X, dx);
		write_reg(rtch_pkg::REG_DIR_Y, dy);
		write_reg(rtch_pkg::REG_DIR_Z, dz);
	endtask

	task send_tri(bit first, logic [15:0] idx, logic [31:0] c[9]);
		logic [303:0] d;
		d[15:0] = idx;
		for (int i = 0; i < 9; i++)
			d[16 + 32 * i +: 32] = c[i];
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= d;
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// whole units to Q16.16
	function automatic logic [31:0] q(int units);
		return units <<< 16;
	endfunction

	function automatic logic [31:0] small_off();
		return $urandom_range(0, 1 << 19) - (1 << 18);
	endfunction

	// mostly triangles built around a point on the ray, some near misses, some noise
	task random_tri();
		logic [31:0] c[9];
		longint pt, e1, e2, uu, vv, tt;
		int kind;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			foreach (c[i]) c[i] = $urandom;
		end else begin
			tt = longint'($urandom_range(0, 10)) - 2;
			uu = $urandom_range(0, kind < 70 ? 65536 : 98304);
			vv = $urandom_range(0, (kind < 70 ? 65536 : 98304) - uu);
			for (int i = 0; i < 3; i++) begin
				pt = longint'($signed(sb.ray[i])) + tt * longint'($signed(sb.ray[3 + i]));
				e1 = longint'($signed(small_off()));
				e2 = longint'($signed(small_off()));
				c[i] = 32'(pt - ((e1 * uu + e2 * vv) >>> 16));
				c[3 + i] = 32'(c[i] + e1);
				c[6 + i] = 32'(c[i] + e2);
			end
		end
		send_tri($urandom_range(5) == 0, 16'($urandom), c);
	endtask

	task directed();
		send_tri(1, 7, '{q(-1), q(-1), q(5), q(3), q(-1), q(5), q(-1), q(3), q(5)});
		// same distance does not replace the record
		send_tri(0, 8, '{q(-1), q(-1), q(5), q(3), q(-1), q(5), q(-1), q(3), q(5)});
		send_tri(0, 9, '{q(-1), q(-1), q(2), q(3), q(-1), q(2), q(-1), q(3), q(2)});
		// behind the origin
		send_tri(0, 10, '{q(-1), q(-1), q(-4), q(3), q(-1), q(-4), q(-1), q(3), q(-4)});
		// parallel to the ray
		send_tri(0, 11, '{q(0), q(0), q(0), q(1), q(0), q(0), q(0), q(0), q(1)});
		// ray through a vertex, u and v both zero
		send_tri(0, 12, '{q(0), q(0), q(1), q(2), q(0), q(1), q(0), q(2), q(1)});
		// u exactly one
		send_tri(0, 13, '{q(-2), q(0), 32'h8000, q(0), q(0), 32'h8000, q(-2), q(2), 32'h8000});
		// off to one side
		send_tri(0, 14, '{q(1), q(1), q(3), q(2), q(1), q(3), q(1), q(2), q(3)});
		// t of zero, then one lsb
		send_tri(0, 15, '{q(-1), q(-1), 0, q(3), q(-1), 0, q(-1), q(3), 0});
		send_tri(0, 16, '{q(-1), q(-1), 1, q(3), q(-1), 1, q(-1), q(3), 1});
		// extreme coordinates and index
		send_tri(1, 16'hFFFF, '{default: 32'h7FFFFFFF});
		send_tri(0, 0, '{32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000});
		send_tri(0, 16'hFFFF, '{q(-1), q(-1), q(32767), q(3), q(-1), q(32767), q(-1), q(3), q(32767)});
		send_tri(1, 0, '{default: 32'h80000000});
		send_tri(0, 16'h5A5A, '{q(-1), q(-1), q(1), q(3), q(-1), q(1), q(-1), q(3), q(1)});
	endtask

	initial begin
		src_idle = 20;
		dst_idle = 65;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			if (ph == 2) begin
				src_idle = 65;
				dst_idle = 20;
			end else if (ph == 4) begin
				src_idle = 0;
				dst_idle = 0;
			end
			case (ph)
				0: set_ray(0, 0, 0, 0, 0, q(1));
				1: set_ray(small_off() <<< 3, small_off() <<< 3, small_off() <<< 3,
					small_off(), small_off(), small_off());
				2: set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
					32'h80000000, 32'h80000000, 32'h80000000);
				3: set_ray(small_off(), small_off(), small_off(), 0, 0, 0);
				4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: set_ray(small_off(), small_off(), small_off(),
					small_off(), small_off(), small_off());
			endcase
			if (ph == 0) begin
				directed();
				src_idle = 20;
			end
			for (int n = 0; n < 240; n++)
				random_tri();
			s_tvalid <= 0;
		end
		wait_idle();
		repeat (300) @(posedge clk);
		$display("ran %0d triangles over six rays, %0d records checked, %0d new closest hits",
			sent, sb.results, sb.hits);
		if (sb.errors == 0 && sb.due.size() == 0)
			$display("PASS ray_triangle_closest_hit");
		else
			$display("FAIL ray_triangle_closest_hit");
		$finish;
	end

	// watchdog
	initial begin
		#40_000_000;
		$display("FAIL ray_triangle_closest_hit");
		$finish;
	end
endmodule
